[rtl/hybrid_exact_log_counter_macros.svh]
// Assertion macros used by the hybrid exact/log counter RTL.
`ifndef HYBRID_EXACT_LOG_COUNTER_MACROS_SVH
`define HYBRID_EXACT_LOG_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
`define HEL_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HEL_ASSERT(lbl, prop, msg) `HEL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define HEL_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define HEL_ASSERT(lbl, prop, msg)
`endif
`endif

[rtl/hel_pkg.sv]
// Types, constants and helper functions of the hybrid exact/log counter.
package hel_pkg;

  localparam logic [7:0]  LogFlag   = 8'h80;
  localparam logic [7:0]  LogSplit  = 8'hC0;
  localparam logic [5:0]  ExpMax    = 6'd63;
  localparam logic [5:0]  ExpLow    = 6'd6;
  localparam logic [5:0]  ExpHigh   = 6'd7;
  localparam logic [63:0] SeedReset = 64'd88172645463325252;
  localparam int unsigned CmdDepth  = 2;
  localparam int unsigned ResDepth  = 2;

  typedef enum logic [1:0] {
    FUNC_INC   = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_MERGE = 2'd2,
    FUNC_READ  = 2'd3
  } hel_func_e;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2
  } hel_op_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_WALK = 5'b00100,
    ST_BITS = 5'b01000,
    ST_DONE = 5'b10000
  } hel_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] amount;
    logic [7:0]  other_word;
  } hel_in_t;

  typedef struct packed {
    logic        changed;
    logic [7:0]  counter_word;
    logic [63:0] estimate;
  } hel_out_t;

  typedef struct packed {
    hel_op_e     op;
    logic [63:0] addend;
  } hel_cmd_t;

  // One xorshift64 step with shifts 13, 7 and 17.
  function automatic logic [63:0] xorshift64(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  // Estimate of exponent v: 2^(v+1)-2, saturating at 2^64-2 for the top exponent.
  function automatic logic [63:0] log_est(input logic [5:0] v);
    logic [63:0] e;
    if (v == ExpMax) begin
      e = 64'hFFFF_FFFF_FFFF_FFFE;
    end else begin
      e = (64'd1 << ({1'b0, v} + 7'd1)) - 64'd2;
    end
    return e;
  endfunction

  function automatic logic [63:0] word_est(input logic [7:0] w);
    logic [63:0] e;
    if (w[7]) begin
      e = log_est((w[6:0] > {1'b0, ExpMax}) ? ExpMax : w[5:0]);
    end else begin
      e = {57'd0, w[6:0]};
    end
    return e;
  endfunction

  // Mask of the k lowest bits, k from 1 to 64.
  function automatic logic [63:0] low_mask(input logic [6:0] k);
    return (64'd1 << k) - 64'd1;
  endfunction

endpackage

[rtl/hel_queue.sv]
// Small register-based first-in first-out queue.
module hel_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/hel_front.sv]
// Front end: turns an accepted item into a command for the execution engine.
module hel_front (
  input  hel_pkg::hel_in_t  in_i,
  output hel_pkg::hel_cmd_t cmd_o
);
  import hel_pkg::*;

  always_comb begin
    cmd_o.op     = OP_READ;
    cmd_o.addend = '0;
    case (in_i.func)
      FUNC_INC: begin
        cmd_o.op = OP_INC;
      end
      FUNC_ADD: begin
        cmd_o.op     = OP_ADD;
        cmd_o.addend = in_i.amount;
      end
      // A merge is an add of the other counter's estimate.
      FUNC_MERGE: begin
        cmd_o.op     = OP_ADD;
        cmd_o.addend = word_est(in_i.other_word);
      end
      FUNC_READ: begin
        cmd_o.op = OP_READ;
      end
      default: begin
        cmd_o.op = OP_READ;
      end
    endcase
  end

endmodule

[rtl/hel_engine.sv]
// Execution engine: holds the counter word and generator state and runs each command.
module hel_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              cmd_empty_i,
  input  hel_pkg::hel_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output hel_pkg::hel_out_t res_o
);
  import hel_pkg::*;

  hel_state_e  state_q, state_d;
  logic [7:0]  word_q, word_d, res_word_q, res_word_d;
  logic [63:0] rng_q, rng_d;
  logic [5:0]  v_q, v_d, shift_q, shift_d;
  logic [63:0] add_q, add_d, sum_q, sum_d, remain_q, remain_d;
  logic [6:0]  second_q, second_d;
  logic        pass2_q, pass2_d;

  logic [63:0] draw;
  logic [5:0]  d_clamp;
  logic        inc_hit, bit_hit;
  logic [64:0] init_sum;
  logic [7:0]  small_sum;
  logic [63:0] step;
  logic        finish;
  logic [5:0]  fin_v;

  assign draw     = xorshift64(rng_q);
  assign d_clamp  = (word_q[6:0] > {1'b0, ExpMax}) ? ExpMax : word_q[5:0];
  assign init_sum = {1'b0, log_est(v_q)} + {1'b0, add_q};
  assign small_sum = {1'b0, word_q[6:0]} + cmd_i.addend[7:0];
  assign step     = 64'd1 << v_q;

  // A draw wins when its trailing zero count exceeds the exponent; an all-zero draw
  // counts as the top exponent.
  assign inc_hit = ((draw & low_mask({1'b0, d_clamp} + 7'd1)) == '0) &&
                   !((draw == '0) && (d_clamp == ExpMax));
  assign bit_hit = (v_q != ExpMax) &&
                   ((draw == '0) || (shift_q > v_q) ||
                    ((draw & low_mask({1'b0, v_q} - {1'b0, shift_q} + 7'd1)) == '0));

  assign res_o.changed      = (res_word_q != word_q);
  assign res_o.counter_word = res_word_q;
  assign res_o.estimate     = word_est(res_word_q);

  always_comb begin
    state_d    = state_q;
    word_d     = word_q;
    res_word_d = res_word_q;
    rng_d      = rng_q;
    v_d        = v_q;
    shift_d    = shift_q;
    add_d      = add_q;
    sum_d      = sum_q;
    remain_d   = remain_q;
    second_d   = second_q;
    pass2_d    = pass2_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    finish     = 1'b0;
    fin_v      = v_q;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          state_d   = ST_DONE;
          case (cmd_i.op)
            OP_INC: begin
              if (!word_q[7]) begin
                res_word_d = (word_q[6:0] == 7'h7F) ? (LogFlag | {2'b00, ExpLow})
                                                    : word_q + 8'd1;
              end else begin
                rng_d      = draw;
                res_word_d = {2'b10, d_clamp + {5'd0, inc_hit}};
              end
            end
            OP_ADD: begin
              if (cmd_i.addend == '0) begin
                res_word_d = word_q;
              end else if (!word_q[7] && (cmd_i.addend[63:7] == '0)) begin
                if (!small_sum[7]) begin
                  res_word_d = small_sum;
                end else begin
                  res_word_d = LogFlag | {2'b00, (small_sum < LogSplit) ? ExpLow : ExpHigh};
                end
              end else if (!word_q[7]) begin
                // A large add to an exact count: add the amount to exponent zero,
                // then the old exact count in a second pass.
                v_d      = '0;
                add_d    = cmd_i.addend;
                second_d = word_q[6:0];
                pass2_d  = 1'b1;
                state_d  = ST_INIT;
              end else begin
                v_d     = d_clamp;
                add_d   = cmd_i.addend;
                pass2_d = 1'b0;
                state_d = ST_INIT;
              end
            end
            OP_READ: begin
              res_word_d = word_q;
            end
            default: begin
              res_word_d = word_q;
            end
          endcase
        end
      end
      ST_INIT: begin
        if (add_q == '0) begin
          finish = 1'b1;
        end else if (init_sum[64]) begin
          finish = 1'b1;
          fin_v  = ExpMax;
        end else begin
          sum_d    = init_sum[63:0];
          remain_d = add_q;
          shift_d  = '0;
          state_d  = ST_WALK;
        end
      end
      ST_WALK: begin
        // Deterministic part: climb while the exact sum reaches the next estimate.
        if ((v_q != ExpMax) && (sum_q >= log_est(v_q + 6'd1))) begin
          remain_d = (step > remain_q) ? '0 : remain_q - step;
          v_d      = v_q + 6'd1;
        end else begin
          state_d = ST_BITS;
        end
      end
      ST_BITS: begin
        // Probabilistic part: one draw for every set bit of what is left.
        if (remain_q == '0) begin
          finish = 1'b1;
        end else begin
          if (remain_q[0]) begin
            rng_d = draw;
            if (bit_hit) begin
              v_d = v_q + 6'd1;
            end
          end
          remain_d = remain_q >> 1;
          shift_d  = shift_q + 6'd1;
        end
      end
      ST_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          word_d     = res_word_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      v_d = fin_v;
      if (pass2_q) begin
        pass2_d = 1'b0;
        add_d   = {57'd0, second_q};
        state_d = ST_INIT;
      end else begin
        res_word_d = {2'b10, fin_v};
        state_d    = ST_DONE;
      end
    end

    if (cfg_we_i) begin
      rng_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      word_q  <= '0;
      rng_q   <= SeedReset;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      rng_q   <= rng_d;
      pass2_q <= pass2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_word_q <= res_word_d;
    v_q        <= v_d;
    shift_q    <= shift_d;
    add_q      <= add_d;
    sum_q      <= sum_d;
    remain_q   <= remain_d;
    second_q   <= second_d;
  end

endmodule

[rtl/hybrid_exact_log_counter.sv]
// Top level of the hybrid exact/logarithmic event counter.
//
// Usage: items enter through a queue-like port: in_data_i is taken at a clock edge
// where push is high and full is low. Results leave the same way: while empty is
// low the oldest result sits on res_data_o and is taken when pop is high.
// Every item gives exactly one result, in order.
// Increments, reads and small adds to an exact count go from the command queue to the
// engine's result register and, in its done state, into the result queue; the engine
// takes the next item only after that push. An add in log mode walks the exponent one
// step per cycle (up to 63) and then draws once per remaining addend bit; a large add
// to an exact count runs that sequence twice. The engine has a single walk/draw
// sequencer, so it takes no new item while an add runs.
// A two-entry command queue and a two-entry result queue sit on either side, so
// new items are taken while results wait; when the receiver stalls the result
// queue fills, the engine holds its finished result and full rises once the
// command queue is also full.
// Reset clears the counter word to zero, loads the default generator seed and
// empties both queues. A write on cfg_we_i loads cfg_data_i as the generator state.
`include "hybrid_exact_log_counter_macros.svh"
module hybrid_exact_log_counter #(
  parameter int unsigned CMD_DEPTH = hel_pkg::CmdDepth,
  parameter int unsigned RES_DEPTH = hel_pkg::ResDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              push,
  input  hel_pkg::hel_in_t  in_data_i,
  output logic              full,
  input  logic              pop,
  output hel_pkg::hel_out_t res_data_o,
  output logic              empty
);
  import hel_pkg::*;

  hel_cmd_t                 front_cmd, cmd_head;
  logic [$bits(hel_cmd_t)-1:0] cmd_vec;
  logic                     cmd_empty, cmd_pop;
  hel_out_t                 res_new;
  logic [$bits(hel_out_t)-1:0] res_vec;
  logic                     res_full, res_push;

  hel_front u_front (
    .in_i  (in_data_i),
    .cmd_o (front_cmd)
  );

  hel_queue #(
    .WIDTH ($bits(hel_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_vec),
    .empty_o (cmd_empty)
  );

  assign cmd_head = hel_cmd_t'(cmd_vec);

  hel_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  hel_queue #(
    .WIDTH ($bits(hel_out_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_vec),
    .empty_o (empty)
  );

  assign res_data_o = hel_out_t'(res_vec);

  `HEL_ASSERT(a_res_push_room, res_push |-> !res_full, "result pushed into a full queue")
  `HEL_ASSERT(a_cmd_pop_valid, cmd_pop |-> !cmd_empty, "command taken from an empty queue")
  `HEL_ASSERT_CLK(a_exp_range, clk_i, rst_ni,
    res_push |-> !(res_new.counter_word[7] && res_new.counter_word[6]),
    "log-mode exponent above 63")

endmodule

[bench/tb_hybrid_exact_log_counter.sv]
// Self-checking testbench for the hybrid exact/log counter: directed rows, random phases.
`timescale 1ns / 1ps
module tb_hybrid_exact_log_counter;
  import hel_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 300;
  localparam logic [63:0] EstTop        = 64'hFFFF_FFFF_FFFF_FFFE;

  typedef struct {
    hel_func_e   op;
    logic [63:0] amount;
    logic [7:0]  other;
    bit          typed;
    hel_out_t    want;
  } script_row_t;

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        push     = 1'b0;
  hel_in_t     item_in  = '0;
  logic        full;
  logic        pop      = 1'b0;
  hel_out_t    res_out;
  logic        empty;

  // Shadow copy of the counter word and the generator state.
  logic [7:0]  shadow_word;
  logic [63:0] shadow_rng;

  hel_out_t    pending_results[$];
  script_row_t script[$];
  int unsigned script_split;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  bit          hung = 1'b0;

  hybrid_exact_log_counter uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .push       (push),
    .in_data_i  (item_in),
    .full       (full),
    .pop        (pop),
    .res_data_o (res_out),
    .empty      (empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] rng_next();
    logic [63:0] x;
    x = shadow_rng;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    shadow_rng = x;
    return x;
  endfunction

  // A draw of zero counts as the largest run of trailing zeros.
  function automatic int unsigned low_zero_run(logic [63:0] r);
    int unsigned n;
    n = 0;
    if (r == 64'd0) return ExpMax;
    while (r[0] == 1'b0) begin
      r = r >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [63:0] exp_estimate(int unsigned v);
    if (v >= ExpMax) return EstTop;
    return (64'd1 << (v + 1)) - 64'd2;
  endfunction

  function automatic logic [63:0] word_estimate(logic [7:0] w);
    if (w[7]) return exp_estimate(w[6:0]);
    return {57'd0, w[6:0]};
  endfunction

  // Walks the exponent up deterministically, then draws once per remaining addend bit.
  function automatic int unsigned exp_add(int unsigned v, logic [63:0] addend);
    logic [63:0] base;
    logic [63:0] total;
    logic [63:0] remain;
    int unsigned bitpos;
    int unsigned z;
    if (addend == 64'd0) return v;
    base = exp_estimate(v);
    if (base > ~addend) return ExpMax;
    total  = base + addend;
    remain = addend;
    while (v < ExpMax) begin
      if (total < exp_estimate(v + 1)) break;
      remain = ((64'd1 << v) > remain) ? 64'd0 : remain - (64'd1 << v);
      v++;
    end
    bitpos = 0;
    while (remain != 64'd0) begin
      if (remain[0]) begin
        z = bitpos + low_zero_run(rng_next());
        if (z > ExpMax) z = ExpMax;
        if (z > v) v++;
      end
      bitpos++;
      remain = remain >> 1;
    end
    return v;
  endfunction

  function automatic logic [7:0] word_add(logic [7:0] w, logic [63:0] addend);
    logic [63:0] total;
    int unsigned e;
    if (addend == 64'd0) return w;
    if (!w[7]) begin
      if (addend < LogFlag) begin
        total = addend + w[6:0];
        if (total < LogFlag) return total[7:0];
        return (total < LogSplit) ? (LogFlag | ExpLow) : (LogFlag | ExpHigh);
      end
      e = exp_add(0, addend);
      e = exp_add(e, {57'd0, w[6:0]});
      return LogFlag | 8'(e);
    end
    e = w[6:0];
    if (e > ExpMax) e = ExpMax;
    return LogFlag | 8'(exp_add(e, addend));
  endfunction

  function automatic logic [7:0] word_inc(logic [7:0] w);
    int unsigned d;
    if (!w[7]) begin
      if (w[6:0] == 7'h7F) return LogFlag | ExpLow;
      return w + 8'd1;
    end
    d = w[6:0];
    if (d > ExpMax) d = ExpMax;
    if (low_zero_run(rng_next()) > d) d++;
    return LogFlag | 8'(d);
  endfunction

  function automatic hel_out_t counter_step(hel_in_t it);
    logic [7:0] prev;
    hel_out_t   r;
    prev = shadow_word;
    case (it.func)
      FUNC_INC:   shadow_word = word_inc(shadow_word);
      FUNC_ADD:   shadow_word = word_add(shadow_word, it.amount);
      FUNC_MERGE: shadow_word = word_add(shadow_word, word_estimate(it.other_word));
      default: ;
    endcase
    r.changed      = (shadow_word != prev);
    r.counter_word = shadow_word;
    r.estimate     = word_estimate(shadow_word);
    return r;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic add_row(input hel_func_e op, input logic [63:0] amount, input logic [7:0] other,
                         input bit typed, input logic chg, input logic [7:0] word,
                         input logic [63:0] est);
    script_row_t r;
    r.op                = op;
    r.amount            = amount;
    r.other             = other;
    r.typed             = typed;
    r.want.changed      = chg;
    r.want.counter_word = word;
    r.want.estimate     = est;
    script.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_one(input hel_in_t it, input bit typed, input hel_out_t want);
    hel_out_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    item_in <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = counter_step(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic load_seed(input logic [63:0] seed);
    wait_all_results();
    cfg_we     <= 1'b1;
    cfg_data   <= seed;
    shadow_rng  = seed;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic walk_rows(input int unsigned lo, input int unsigned hi);
    hel_in_t it;
    for (int unsigned i = lo; i < hi; i++) begin
      it.func       = script[i].op;
      it.amount     = script[i].amount;
      it.other_word = script[i].other;
      send_one(it, script[i].typed, script[i].want);
    end
  endtask

  // Amount widths and merged exponents are capped per phase, because the exponent never
  // falls and would otherwise saturate early and leave the rest of the run trivial.
  task automatic run_phase(input logic [63:0] seed, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned count,
                           input int unsigned max_width, input int unsigned max_exp);
    hel_in_t     it;
    int unsigned pick;
    int unsigned width;
    int unsigned pause_at;
    logic [63:0] raw;
    load_seed(seed);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    pause_at = $urandom_range(count - 1);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == pause_at) wait_all_results();
      pick = $urandom_range(99);
      if (pick < 30) it.func = FUNC_INC;
      else if (pick < 65) it.func = FUNC_ADD;
      else if (pick < 85) it.func = FUNC_MERGE;
      else it.func = FUNC_READ;
      width = $urandom_range(max_width);
      raw   = {$urandom, $urandom};
      if ($urandom_range(7) == 0) it.amount = 64'd0;
      else if (width >= 64) it.amount = raw;
      else it.amount = raw & ((64'd1 << width) - 64'd1);
      if ($urandom_range(1) == 0) it.other_word = {1'b0, 7'($urandom)};
      else it.other_word = {1'b1, 7'($urandom_range(max_exp))};
      send_one(it, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    hel_out_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result %02h with nothing expected", res_out.counter_word));
      end else begin
        want = pending_results.pop_front();
        if (res_out.changed !== want.changed)
          flag_error($sformatf("changed: expected %0b, got %0b", want.changed,
                               res_out.changed));
        if (res_out.counter_word !== want.counter_word)
          flag_error($sformatf("counter_word: expected %02h, got %02h", want.counter_word,
                               res_out.counter_word));
        if (res_out.estimate !== want.estimate)
          flag_error($sformatf("estimate: expected %016h, got %016h", want.estimate,
                               res_out.estimate));
      end
    end
  end

  // Cycles since the last transfer on either side.
  always @(posedge clk) begin
    if (!rst_n) idle_cycles <= 0;
    else if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    hel_func_e   cross_op;
    logic [63:0] cross_amount;
    logic [7:0]  cross_other;
    shadow_word = 8'h00;
    shadow_rng  = SeedReset;

    // Exact-mode rows, then the one crossing into log mode that a run can make.
    add_row(FUNC_READ,  64'd0,   8'h00, 1'b1, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_INC,   64'd0,   8'h00, 1'b1, 1'b1, 8'h01, 64'd1);
    add_row(FUNC_ADD,   64'd0,   8'h00, 1'b1, 1'b0, 8'h01, 64'd1);
    add_row(FUNC_MERGE, 64'd0,   8'h00, 1'b1, 1'b0, 8'h01, 64'd1);
    add_row(FUNC_MERGE, 64'd0,   8'h80, 1'b1, 1'b0, 8'h01, 64'd1);
    add_row(FUNC_MERGE, 64'd0,   8'h81, 1'b1, 1'b1, 8'h03, 64'd3);
    add_row(FUNC_MERGE, 64'd0,   8'h05, 1'b1, 1'b1, 8'h08, 64'd8);
    add_row(FUNC_ADD,   64'd119, 8'h00, 1'b1, 1'b1, 8'h7F, 64'd127);
    add_row(FUNC_READ,  64'd0,   8'h00, 1'b1, 1'b0, 8'h7F, 64'd127);
    cross_amount = 64'd0;
    cross_other  = 8'h00;
    case ($urandom_range(4))
      0: cross_op = FUNC_INC;
      1: begin
        cross_op     = FUNC_ADD;
        cross_amount = 64'd64;
      end
      2: begin
        cross_op     = FUNC_ADD;
        cross_amount = 64'd65;
      end
      3: begin
        cross_op     = FUNC_ADD;
        cross_amount = 64'($urandom_range(1 << 20, 128));
      end
      default: begin
        cross_op    = FUNC_MERGE;
        cross_other = {1'b1, 7'($urandom_range(20, 7))};
      end
    endcase
    add_row(cross_op,   cross_amount, cross_other, 1'b0, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_INC,   64'd0, 8'h00, 1'b0, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_ADD,   64'd1, 8'h00, 1'b0, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_MERGE, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_READ,  64'd0, 8'h00, 1'b0, 1'b0, 8'h00, 64'd0);
    script_split = script.size();
    // Saturation rows close the run: once at the top exponent the word cannot move again.
    add_row(FUNC_ADD,   64'h8000_0000_0000_0000, 8'h00, 1'b0, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_MERGE, 64'd0, 8'hC5, 1'b0, 1'b0, 8'h00, 64'd0);
    add_row(FUNC_INC,   64'd0, 8'h00, 1'b1, 1'b0, 8'hBF, EstTop);
    add_row(FUNC_ADD,   '1,    8'h00, 1'b1, 1'b0, 8'hBF, EstTop);
    add_row(FUNC_MERGE, 64'd0, 8'hFF, 1'b1, 1'b0, 8'hBF, EstTop);
    add_row(FUNC_ADD,   64'd0, 8'h00, 1'b1, 1'b0, 8'hBF, EstTop);
    add_row(FUNC_READ,  64'd0, 8'h00, 1'b1, 1'b0, 8'hBF, EstTop);

    fork
      begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        walk_rows(0, script_split);
        run_phase('1, 0, 0, 300, 12, 10);
        run_phase(64'd1, 81, 0, 300, 20, 18);
        run_phase({$urandom, $urandom} | 64'd1, 0, 81, 300, 40, 36);
        run_phase(64'd0, 37, 37, 250, 64, 127);
        walk_rows(script_split, script.size());
        receiver_stall_pct = 0;
        wait_all_results();
        repeat (TailCycles) @(negedge clk);
      end
      begin
        wait (idle_cycles >= WatchdogLimit);
        hung = 1'b1;
      end
    join_any
    if (hung) $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
    if (!hung && error_count == 0 && pending_results.size() == 0) begin
      $display("tb_hybrid_exact_log_counter: PASS");
    end else begin
      $display("tb_hybrid_exact_log_counter: FAIL");
    end
    $finish;
  end

endmodule
